// ===== src/obd2c_pkg.sv =====
// Shared types, codes and helper functions for the OBD-II request/response client.
// No dependencies; used by src/obd2_request_response_client.sv.
package obd2c_pkg;

  // Input command codes
  localparam logic [2:0] CMD_READ_PID   = 3'd0;
  localparam logic [2:0] CMD_READ_CODES = 3'd1;
  localparam logic [2:0] CMD_CLEAR      = 3'd2;
  localparam logic [2:0] CMD_FRAME      = 3'd3;
  localparam logic [2:0] CMD_TICK       = 3'd4;

  // Result kinds
  localparam logic [2:0] KIND_TX        = 3'd0;
  localparam logic [2:0] KIND_PID_VALUE = 3'd1;
  localparam logic [2:0] KIND_PID_FAIL  = 3'd2;
  localparam logic [2:0] KIND_CODE      = 3'd3;
  localparam logic [2:0] KIND_DONE      = 3'd4;

  // Service modes and reply bytes
  localparam logic [2:0] MODE_PID   = 3'd1;
  localparam logic [2:0] MODE_CODES = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;
  localparam logic [7:0] REPLY_PID   = 8'h41;
  localparam logic [7:0] REPLY_CODES = 8'h43;

  // Receive identifier window
  localparam logic [10:0] RX_ID_LO = 11'h7E8;
  localparam logic [10:0] RX_ID_HI = 11'h7EF;

  // Supported pids
  localparam logic [7:0] PID_RPM      = 8'h0C;
  localparam logic [7:0] PID_SPEED    = 8'h0D;
  localparam logic [7:0] PID_COOLANT  = 8'h05;
  localparam logic [7:0] PID_THROTTLE = 8'h11;
  localparam logic [7:0] PID_VOLTAGE  = 8'h42;

  // Configuration register indexes
  localparam logic REG_MAX_CODES  = 1'b0;
  localparam logic REG_TIMEOUT_MS = 1'b1;

  localparam int unsigned MaxCodesReset  = 3;
  localparam int unsigned TimeoutMsReset = 200;

  typedef enum logic [2:0] {
    WAIT_NONE  = 3'b001,
    WAIT_PID   = 3'b010,
    WAIT_CODES = 3'b100
  } wait_t;

  // Payload of the closing result of a batch
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  tx_length;
    logic [2:0]  tx_mode;
    logic [7:0]  tx_pid;
    logic [24:0] value_milli;
    logic [1:0]  code_count;
  } final_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'd0, n};
    end else begin
      c = 8'h37 + {4'd0, n};
    end
    return c;
  endfunction

  // Five ASCII characters, first character in the top byte
  function automatic logic [39:0] dtc_text(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] letter;
    case (hi[7:6])
      2'd0:    letter = 8'h50;
      2'd1:    letter = 8'h43;
      2'd2:    letter = 8'h42;
      default: letter = 8'h55;
    endcase
    return {letter, 8'h30 | {6'd0, hi[5:4]}, hex_char(hi[3:0]),
            hex_char(lo[7:4]), hex_char(lo[3:0])};
  endfunction

endpackage

// ===== src/obd2_request_response_client.sv =====
// OBD-II request/response client: command decode, reply scaling, trouble code
// formatting and timeout. Depends on src/obd2c_pkg.sv.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in_     | slave     | in_tvalid / in_tready   | in_tuser command, in_tdata pid..byte7
//  out_    | master    | out_tvalid / out_tready | out_tuser kind, out_tdata, out_tlast
//  cfg_    | APB slave | psel/penable/pready     | max_codes @0x0, timeout_ms @0x4
//
// Each item is held in an input register, decoded by short logic and loaded into a
// result batch register (up to three codes plus a closing result). A batch drains
// one result per cycle while out_tready is high; a command thus yields one result,
// a code reply one per code plus the closing one, bounded by the single batch register.
// Synchronous active-low reset: nothing pending, max_codes 3, timeout_ms 200.
// A stalled output holds the batch; the input register then fills and in_tready drops.
module obd2_request_response_client (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // command
  input  logic [79:0] in_tdata,   // pid, can_id, byte1..byte7, zero pad
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // result_kind
  output logic [79:0] out_tdata,  // tx_length, tx_mode, tx_pid, value_milli, code_text,
                                  // code_count
  output logic        out_tlast,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0] max_codes_r;
  logic [9:0] timeout_ms_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_codes_r  <= 2'(obd2c_pkg::MaxCodesReset);
      timeout_ms_r <= 10'(obd2c_pkg::TimeoutMsReset);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == obd2c_pkg::REG_MAX_CODES) begin
        max_codes_r <= cfg_pwdata[1:0];
      end else begin
        timeout_ms_r <= cfg_pwdata[9:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == obd2c_pkg::REG_TIMEOUT_MS) begin
      cfg_prdata = {22'd0, timeout_ms_r};
    end else begin
      cfg_prdata = {30'd0, max_codes_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic        in_vld_r;
  logic [2:0]  in_cmd_r;
  logic [74:0] in_data_r;
  logic        proc_go;
  logic        batch_free;

  assign in_tready = !in_vld_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r  <= in_tuser;
      in_data_r <= in_tdata[74:0];
    end
  end

  logic [7:0]  f_pid;
  logic [10:0] f_id;
  logic [7:0]  f_b1, f_b2, f_b3, f_b4, f_b5, f_b6, f_b7;

  assign f_pid = in_data_r[7:0];
  assign f_id  = in_data_r[18:8];
  assign f_b1  = in_data_r[26:19];
  assign f_b2  = in_data_r[34:27];
  assign f_b3  = in_data_r[42:35];
  assign f_b4  = in_data_r[50:43];
  assign f_b5  = in_data_r[58:51];
  assign f_b6  = in_data_r[66:59];
  assign f_b7  = in_data_r[74:67];

  // ---------------------------------------------------------------------------
  // Pending read state
  // ---------------------------------------------------------------------------
  obd2c_pkg::wait_t waiting_for_r, waiting_for_nxt;
  logic [7:0]       wanted_pid_r, wanted_pid_nxt;
  logic [9:0]       time_left_r, time_left_nxt;

  // ---------------------------------------------------------------------------
  // Pid scaling, all on bytes A (byte3) and B (byte4)
  // ---------------------------------------------------------------------------
  logic [24:0] v_rpm, v_speed, v_cool, v_thr, v_volt, v_pid;
  logic [13:0] thr_frac_in;
  logic [14:0] thr_frac_sum;
  logic        pid_ok;

  assign v_rpm   = {9'd0, f_b3, f_b4} * 25'd250;
  assign v_speed = {17'd0, f_b3} * 25'd1000;
  assign v_cool  = ({17'd0, f_b3} - 25'd40) * 25'd1000;
  assign v_volt  = {9'd0, f_b3, f_b4};
  // A*100000/255 = A*392 + floor(A*40/255); the small quotient by the 255 identity
  assign thr_frac_in  = {6'd0, f_b3} * 14'd40;
  assign thr_frac_sum = {1'b0, thr_frac_in} + 15'd1 + {9'd0, thr_frac_in[13:8]};
  assign v_thr        = {17'd0, f_b3} * 25'd392 + {18'd0, thr_frac_sum[14:8]};

  always_comb begin
    pid_ok = 1'b1;
    unique case (wanted_pid_r)
      obd2c_pkg::PID_RPM:      v_pid = v_rpm;
      obd2c_pkg::PID_SPEED:    v_pid = v_speed;
      obd2c_pkg::PID_COOLANT:  v_pid = v_cool;
      obd2c_pkg::PID_THROTTLE: v_pid = v_thr;
      obd2c_pkg::PID_VOLTAGE:  v_pid = v_volt;
      default: begin
        v_pid  = '0;
        pid_ok = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Trouble code selection: take nonzero slots in order, up to max_codes
  // ---------------------------------------------------------------------------
  logic [39:0] txt0, txt1, txt2;
  logic        nz0, nz1, nz2, take0, take1, take2;
  logic [1:0]  cnt0, cnt1, code_cnt;

  assign txt0 = obd2c_pkg::dtc_text(f_b2, f_b3);
  assign txt1 = obd2c_pkg::dtc_text(f_b4, f_b5);
  assign txt2 = obd2c_pkg::dtc_text(f_b6, f_b7);
  assign nz0  = (f_b2 != 8'd0) || (f_b3 != 8'd0);
  assign nz1  = (f_b4 != 8'd0) || (f_b5 != 8'd0);
  assign nz2  = (f_b6 != 8'd0) || (f_b7 != 8'd0);

  assign take0    = nz0 && (max_codes_r != 2'd0);
  assign cnt0     = {1'b0, take0};
  assign take1    = nz1 && (cnt0 < max_codes_r);
  assign cnt1     = cnt0 + {1'b0, take1};
  assign take2    = nz2 && (cnt1 < max_codes_r);
  assign code_cnt = cnt1 + {1'b0, take2};

  // ---------------------------------------------------------------------------
  // Item decode: next state and the batch to load
  // ---------------------------------------------------------------------------
  logic                  id_ok;
  logic                  load;
  logic [1:0]            load_ncode;
  obd2c_pkg::final_t     load_fin;
  logic [39:0]           load_code [3];

  assign id_ok = (f_id >= obd2c_pkg::RX_ID_LO) && (f_id <= obd2c_pkg::RX_ID_HI);

  always_comb begin
    waiting_for_nxt = waiting_for_r;
    wanted_pid_nxt  = wanted_pid_r;
    time_left_nxt   = time_left_r;
    load            = 1'b0;
    load_ncode      = 2'd0;
    load_fin        = '0;
    load_code[0]    = take0 ? txt0 : (take1 ? txt1 : txt2);
    load_code[1]    = (take0 && take1) ? txt1 : txt2;
    load_code[2]    = txt2;
    unique case (in_cmd_r)
      obd2c_pkg::CMD_READ_PID: begin
        waiting_for_nxt    = obd2c_pkg::WAIT_PID;
        wanted_pid_nxt     = f_pid;
        time_left_nxt      = timeout_ms_r;
        load               = 1'b1;
        load_fin.kind      = obd2c_pkg::KIND_TX;
        load_fin.tx_length = 2'd2;
        load_fin.tx_mode   = obd2c_pkg::MODE_PID;
        load_fin.tx_pid    = f_pid;
      end
      obd2c_pkg::CMD_READ_CODES: begin
        waiting_for_nxt    = obd2c_pkg::WAIT_CODES;
        time_left_nxt      = timeout_ms_r;
        load               = 1'b1;
        load_fin.kind      = obd2c_pkg::KIND_TX;
        load_fin.tx_length = 2'd1;
        load_fin.tx_mode   = obd2c_pkg::MODE_CODES;
      end
      obd2c_pkg::CMD_CLEAR: begin
        // leave any pending read alone
        load               = 1'b1;
        load_fin.kind      = obd2c_pkg::KIND_TX;
        load_fin.tx_length = 2'd1;
        load_fin.tx_mode   = obd2c_pkg::MODE_CLEAR;
      end
      obd2c_pkg::CMD_FRAME: begin
        if (id_ok) begin
          unique case (waiting_for_r)
            obd2c_pkg::WAIT_PID: begin
              if ((f_b1 == obd2c_pkg::REPLY_PID) && (f_b2 == wanted_pid_r)) begin
                waiting_for_nxt      = obd2c_pkg::WAIT_NONE;
                time_left_nxt        = '0;
                load                 = 1'b1;
                load_fin.kind        = pid_ok ? obd2c_pkg::KIND_PID_VALUE
                                              : obd2c_pkg::KIND_PID_FAIL;
                load_fin.value_milli = v_pid;
              end
            end
            obd2c_pkg::WAIT_CODES: begin
              if (f_b1 == obd2c_pkg::REPLY_CODES) begin
                waiting_for_nxt     = obd2c_pkg::WAIT_NONE;
                time_left_nxt       = '0;
                load                = 1'b1;
                load_ncode          = code_cnt;
                load_fin.kind       = obd2c_pkg::KIND_DONE;
                load_fin.code_count = code_cnt;
              end
            end
            default: ;
          endcase
        end
      end
      obd2c_pkg::CMD_TICK: begin
        if (waiting_for_r != obd2c_pkg::WAIT_NONE) begin
          if (time_left_r > 10'd1) begin
            time_left_nxt = time_left_r - 10'd1;
          end else begin
            // timed out: a pid failure or an empty code report
            time_left_nxt   = '0;
            waiting_for_nxt = obd2c_pkg::WAIT_NONE;
            load            = 1'b1;
            load_fin.kind   = (waiting_for_r == obd2c_pkg::WAIT_PID)
                              ? obd2c_pkg::KIND_PID_FAIL : obd2c_pkg::KIND_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_for_r <= obd2c_pkg::WAIT_NONE;
      wanted_pid_r  <= '0;
      time_left_r   <= '0;
    end else if (proc_go) begin
      waiting_for_r <= waiting_for_nxt;
      wanted_pid_r  <= wanted_pid_nxt;
      time_left_r   <= time_left_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result batch: codes first, then the closing result marked last
  // ---------------------------------------------------------------------------
  logic              busy_r, busy_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [1:0]        ncode_r;
  obd2c_pkg::final_t fin_r;
  logic [39:0]       code_r [3];
  logic              out_fire;
  logic              at_final;

  assign out_fire   = out_tvalid && out_tready;
  assign at_final   = (pos_r == ncode_r);
  assign batch_free = !busy_r || (out_fire && at_final);
  assign proc_go    = in_vld_r && batch_free;

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (out_fire) begin
      if (at_final) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
    if (proc_go && load) begin
      busy_nxt = 1'b1;
      pos_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pos_r   <= '0;
      ncode_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
      if (proc_go && load) begin
        ncode_r <= load_ncode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && load) begin
      fin_r     <= load_fin;
      code_r[0] <= load_code[0];
      code_r[1] <= load_code[1];
      code_r[2] <= load_code[2];
    end
  end

  assign out_tvalid = busy_r;

  always_comb begin
    if (at_final) begin
      out_tuser = fin_r.kind;
      out_tlast = 1'b1;
      out_tdata = {fin_r.code_count, 40'd0, fin_r.value_milli, fin_r.tx_pid,
                   fin_r.tx_mode, fin_r.tx_length};
    end else begin
      out_tuser = obd2c_pkg::KIND_CODE;
      out_tlast = 1'b0;
      out_tdata = {2'd0, code_r[pos_r], 25'd0, 8'd0, 3'd0, 2'd0};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pos_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pos_r <= ncode_r))
    else $error("batch position past closing result");

  a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (waiting_for_r == obd2c_pkg::WAIT_NONE) |-> (time_left_r == 10'd0))
    else $error("timer running with nothing pending");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && busy_r))
    else $error("input stalled without a held item and a busy batch");

  a_drain_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !at_final) |=> (busy_r && (pos_r == $past(pos_r) + 2'd1)))
    else $error("code result taken but batch did not advance");

endmodule
